/* rtl/core/harmonic_chain_verlet_step_defines.svh */
// ----------------------------------------------------------------------------
// harmonic_chain_verlet_step_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef HARMONIC_CHAIN_VERLET_STEP_DEFINES_SVH
`define HARMONIC_CHAIN_VERLET_STEP_DEFINES_SVH

// same-cycle implication
`define HCV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("harmonic chain assertion failed");

// next-cycle implication
`define HCV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("harmonic chain assertion failed");

`endif

/* rtl/core/hcv_pkg.sv */
// ----------------------------------------------------------------------------
// hcv_pkg
// Types, codes and arithmetic helpers of the harmonic chain stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package hcv_pkg;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic [15:0] TIME_STEP_RESET = 16'd6554;

  // cell operations, broadcast to the whole row
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACC,
    OP_MULK,
    OP_KICK,
    OP_MULD,
    OP_DRIFT,
    OP_ROT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] load_idx;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC1,
    S_MUL1,
    S_KICK1,
    S_MULD,
    S_DRIFT,
    S_ACC2,
    S_MUL2,
    S_KICK2,
    S_EMIT
  } seq_state_t;

  // clamp a 36-bit signed sum to 32-bit signed
  function automatic logic signed [31:0] sat36(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sd2147483647)       r = 32'sh7fffffff;
    else if (x < -36'sd2147483648) r = 32'sh80000000;
    else                           r = x[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hcv_in_if.sv */
// ----------------------------------------------------------------------------
// hcv_in_if
// Input channel: load or step command.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcv_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [4:0]         particle_index;
  logic signed [31:0] load_position;
  logic signed [31:0] load_velocity;

  modport source (output valid, func, particle_index, load_position, load_velocity,
                  input ready);
  modport sink   (input valid, func, particle_index, load_position, load_velocity,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/hcv_out_if.sv */
// ----------------------------------------------------------------------------
// hcv_out_if
// Output channel: one particle state per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcv_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         out_index;
  logic signed [31:0] position_out;
  logic signed [31:0] velocity_out;
  logic               last_of_step;

  modport source (output valid, out_index, position_out, velocity_out, last_of_step,
                  input ready);
  modport sink   (input valid, out_index, position_out, velocity_out, last_of_step,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/hcv_cfg_if.sv */
// ----------------------------------------------------------------------------
// hcv_cfg_if
// Configuration write channel for the time step register.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcv_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/hcv_cell.sv */
// ----------------------------------------------------------------------------
// hcv_cell
// One particle: position, velocity, Laplacian and one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module hcv_cell #(
  parameter int IDX = 0
) (
  input  wire                    clk,
  input  wire                    rst,
  input  hcv_pkg::cell_cmd_t     cmd,
  input  wire [15:0]             time_step,
  input  wire signed [31:0]      load_position,
  input  wire signed [31:0]      load_velocity,
  input  wire signed [31:0]      left_pos,
  input  wire signed [31:0]      right_pos,
  input  wire signed [31:0]      rot_pos,
  input  wire signed [31:0]      rot_vel,
  output logic signed [31:0]     pos,
  output logic signed [31:0]     vel
);

  logic signed [33:0] acc;
  logic signed [50:0] prod;
  logic signed [16:0] dt_s;
  logic signed [50:0] rk;
  logic signed [50:0] rd;
  logic signed [35:0] kick_sum;
  logic signed [35:0] drift_sum;
  logic               hit;

  assign dt_s = $signed({1'b0, time_step});
  // round half up: add half an LSB, then floor
  assign rk = prod + 51'sd65536;
  assign rd = prod + 51'sd32768;
  assign kick_sum  = 36'(vel) + 36'($signed(rk[50:17]));
  assign drift_sum = 36'(pos) + 36'($signed(rd[48:16]));
  assign hit = (IDX < 32) && (cmd.load_idx == 5'(IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
    end else begin
      case (cmd.op)
        hcv_pkg::OP_LOAD: begin
          if (hit) begin
            pos <= load_position;
            vel <= load_velocity;
          end
        end
        hcv_pkg::OP_KICK:  vel <= hcv_pkg::sat36(kick_sum);
        hcv_pkg::OP_DRIFT: pos <= hcv_pkg::sat36(drift_sum);
        hcv_pkg::OP_ROT: begin
          pos <= rot_pos;
          vel <= rot_vel;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      hcv_pkg::OP_ACC:  acc  <= 34'(left_pos) + 34'(right_pos) - (34'(pos) <<< 1);
      hcv_pkg::OP_MULK: prod <= 51'(dt_s) * 51'(acc);
      hcv_pkg::OP_MULD: prod <= 51'(dt_s) * 51'(vel);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/hcv_seq.sv */
// ----------------------------------------------------------------------------
// hcv_seq
// Step sequencer: phase commands to the row and output beat count.
// ----------------------------------------------------------------------------
`default_nettype none

module hcv_seq #(
  parameter int NUM_PARTICLES = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_func,
  input  wire [4:0]           in_index,
  output logic                in_ready,
  input  wire                 out_ready,
  output logic                out_valid,
  output logic [4:0]          out_index,
  output logic                out_last,
  output hcv_pkg::cell_cmd_t  cmd
);

  localparam int CW = $clog2(NUM_PARTICLES);

  hcv_pkg::seq_state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcv_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign out_index = 5'(cnt);
  assign out_last  = (cnt == CW'(NUM_PARTICLES - 1));

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.op       = hcv_pkg::OP_NONE;
    cmd.load_idx = in_index;
    unique case (state)
      hcv_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == hcv_pkg::FUNC_LOAD) cmd.op = hcv_pkg::OP_LOAD;
          else state_next = hcv_pkg::S_ACC1;
        end
      end
      hcv_pkg::S_ACC1: begin
        cmd.op = hcv_pkg::OP_ACC;
        state_next = hcv_pkg::S_MUL1;
      end
      hcv_pkg::S_MUL1: begin
        cmd.op = hcv_pkg::OP_MULK;
        state_next = hcv_pkg::S_KICK1;
      end
      hcv_pkg::S_KICK1: begin
        cmd.op = hcv_pkg::OP_KICK;
        state_next = hcv_pkg::S_MULD;
      end
      hcv_pkg::S_MULD: begin
        cmd.op = hcv_pkg::OP_MULD;
        state_next = hcv_pkg::S_DRIFT;
      end
      hcv_pkg::S_DRIFT: begin
        cmd.op = hcv_pkg::OP_DRIFT;
        state_next = hcv_pkg::S_ACC2;
      end
      hcv_pkg::S_ACC2: begin
        cmd.op = hcv_pkg::OP_ACC;
        state_next = hcv_pkg::S_MUL2;
      end
      hcv_pkg::S_MUL2: begin
        cmd.op = hcv_pkg::OP_MULK;
        state_next = hcv_pkg::S_KICK2;
      end
      hcv_pkg::S_KICK2: begin
        cmd.op = hcv_pkg::OP_KICK;
        cnt_next = '0;
        state_next = hcv_pkg::S_EMIT;
      end
      hcv_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.op = hcv_pkg::OP_ROT;
          if (out_last) begin
            cnt_next   = '0;
            state_next = hcv_pkg::S_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: state_next = hcv_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/harmonic_chain_verlet_step.sv */
// ----------------------------------------------------------------------------
// harmonic_chain_verlet_step
// Velocity Verlet stepper for a fixed-end harmonic chain, Q16.16.
// ----------------------------------------------------------------------------
// A load beat (func 0) writes one particle as it is taken; indexes at or
// past NUM_PARTICLES are dropped. A step beat (func 1) runs eight phases
// over the whole row at once (Laplacian, kick product, kick, drift product,
// drift, Laplacian, kick product, kick), then sends NUM_PARTICLES output
// beats from cell 0, rotating the row by one cell per beat so the state is
// back in place after the last beat. A sink stall holds the current output
// beat. The next input beat can be taken in the cycle after the last output
// beat. Input is taken only while idle; each cell's one multiplier sets the
// phase count. time_step may be written at any time but should only change
// idle.
`default_nettype none

module harmonic_chain_verlet_step #(
  parameter int NUM_PARTICLES = 32
) (
  input wire         clk,
  input wire         rst,
  hcv_in_if.sink     in_ch,
  hcv_out_if.source  out_ch,
  hcv_cfg_if.sink    cfg
);

  logic [15:0]         time_step;
  hcv_pkg::cell_cmd_t  cmd;
  logic signed [31:0]  pos_a [NUM_PARTICLES];
  logic signed [31:0]  vel_a [NUM_PARTICLES];

  // time step register, always writable
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= hcv_pkg::TIME_STEP_RESET;
    end else if (cfg.valid) begin
      time_step <= cfg.data;
    end
  end

  hcv_seq #(.NUM_PARTICLES(NUM_PARTICLES)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_index  (in_ch.particle_index),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_index (out_ch.out_index),
    .out_last  (out_ch.last_of_step),
    .cmd       (cmd)
  );

  // row of cells; walls outside both ends, ring for the output rotation
  for (genvar i = 0; i < NUM_PARTICLES; i++) begin : g_cell
    logic signed [31:0] lp, rp;
    assign lp = (i == 0) ? 32'sd0 : pos_a[(i == 0) ? 0 : i - 1];
    assign rp = (i == NUM_PARTICLES - 1) ? 32'sd0
              : pos_a[(i == NUM_PARTICLES - 1) ? i : i + 1];
    hcv_cell #(.IDX(i)) u_cell (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .time_step     (time_step),
      .load_position (in_ch.load_position),
      .load_velocity (in_ch.load_velocity),
      .left_pos      (lp),
      .right_pos     (rp),
      .rot_pos       (pos_a[(i + 1) % NUM_PARTICLES]),
      .rot_vel       (vel_a[(i + 1) % NUM_PARTICLES]),
      .pos           (pos_a[i]),
      .vel           (vel_a[i])
    );
  end

  assign out_ch.position_out = pos_a[0];
  assign out_ch.velocity_out = vel_a[0];

endmodule

`default_nettype wire

/* rtl/core/hcv_checker.sv */
// ----------------------------------------------------------------------------
// hcv_checker
// Port-level checks on the stepper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "harmonic_chain_verlet_step_defines.svh"

module hcv_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [4:0] out_index,
  input wire       out_last
);

  `HCV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_index))
  `HCV_ASSERT_NOW(a_no_in_while_emit, out_valid, !in_ready)
  `HCV_ASSERT_NEXT(a_end_after_last, out_valid && out_ready && out_last, !out_valid)
  `HCV_ASSERT_NEXT(a_burst_runs, out_valid && out_ready && !out_last, out_valid)
  `HCV_ASSERT_NEXT(a_index_steps, out_valid && out_ready && !out_last, out_index == $past(out_index) + 5'd1)

endmodule

bind harmonic_chain_verlet_step hcv_checker u_hcv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.out_index),
  .out_last  (out_ch.last_of_step)
);

`default_nettype wire

/* tb/sv/tb_harmonic_chain_verlet_step.sv */
// ----------------------------------------------------------------------------
// tb_harmonic_chain_verlet_step
// Self-checking bench: loads chain states, runs steps, compares every beat.
// ----------------------------------------------------------------------------
// A predictor keeps its own copy of the chain and dt, runs the velocity Verlet
// step in Q16.16 with saturation, and queues the 32 expected beats per step.
// A monitor pops one expectation per accepted output beat.
`default_nettype none

module tb_harmonic_chain_verlet_step;

  localparam int NP = 32;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [4:0]         idx;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               last;
  } state_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hcv_in_if  in_ch();
  hcv_out_if out_ch();
  hcv_cfg_if cfg();

  harmonic_chain_verlet_step #(.NUM_PARTICLES(NP)) u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] chain_pos [NP];
  logic signed [31:0] chain_vel [NP];
  logic [15:0]        dt_model;
  state_beat_t        expected_beats [$];

  int  error_count = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;     // no random idling in the last part

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  // round x / 2^s, halves toward +inf; arithmetic shift floors, so adding the
  // half then shifting gives exactly that
  function automatic longint round_shr(input longint x, input int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic void kick_all();
    longint acc [NP];
    longint l, r;
    for (int i = 0; i < NP; i++) begin
      l = (i > 0) ? longint'(chain_pos[i-1]) : 0;
      r = (i < NP - 1) ? longint'(chain_pos[i+1]) : 0;
      acc[i] = l - 2 * longint'(chain_pos[i]) + r;
    end
    for (int i = 0; i < NP; i++)
      chain_vel[i] = clamp32(longint'(chain_vel[i]) +
                             round_shr(longint'({1'b0, dt_model}) * acc[i], 17));
  endfunction

  function automatic void predict_beat(input logic f, input logic [4:0] pi,
                                       input logic signed [31:0] lp,
                                       input logic signed [31:0] lv);
    state_beat_t b;
    if (f == hcv_pkg::FUNC_LOAD) begin
      if (pi < NP) begin
        chain_pos[pi] = lp;
        chain_vel[pi] = lv;
      end
      return;
    end
    kick_all();
    for (int i = 0; i < NP; i++)
      chain_pos[i] = clamp32(longint'(chain_pos[i]) +
                     round_shr(longint'({1'b0, dt_model}) * longint'(chain_vel[i]), 16));
    kick_all();
    for (int i = 0; i < NP; i++) begin
      b.idx  = 5'(i);
      b.pos  = chain_pos[i];
      b.vel  = chain_vel[i];
      b.last = (i == NP - 1);
      expected_beats.push_back(b);
    end
  endfunction

  // random input idling; valid drops for the whole gap
  task automatic random_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // send one beat; valid stays high across back-to-back beats
  task automatic send_beat(input logic f, input logic [4:0] pi,
                           input logic signed [31:0] lp, input logic signed [31:0] lv);
    random_gap();
    in_ch.valid          <= 1'b1;
    in_ch.func           <= f;
    in_ch.particle_index <= pi;
    in_ch.load_position  <= lp;
    in_ch.load_velocity  <= lv;
    do @(posedge clk); while (!in_ch.ready);
    predict_beat(f, pi, lp, lv);
  endtask

  // write dt only when idle: drain, then allow for the step latency
  task automatic write_dt(input logic [15:0] v);
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    dt_model = v;
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
    endcase
  endfunction

  task automatic load_random_chain();
    for (int i = 0; i < NP; i++)
      send_beat(hcv_pkg::FUNC_LOAD, 5'(i), rand_q(), rand_q());
  endtask

  task automatic test_directed();
    send_beat(hcv_pkg::FUNC_STEP, 5'd0, 32'sd0, 32'sd0);   // all-zero chain
    send_beat(hcv_pkg::FUNC_LOAD, 5'd0, 32'sh7fffffff, 32'sh7fffffff);
    send_beat(hcv_pkg::FUNC_LOAD, 5'd31, 32'sh80000000, 32'sh80000000);
    send_beat(hcv_pkg::FUNC_LOAD, 5'd15, 32'sh00010000, 32'shffff0000);
    send_beat(hcv_pkg::FUNC_LOAD, 5'd16, 32'shffffffff, 32'sh00000001);
    send_beat(hcv_pkg::FUNC_STEP, 5'd31, 32'shffffffff, 32'shffffffff);
    send_beat(hcv_pkg::FUNC_STEP, 5'd0, 32'sd0, 32'sd0);
    write_dt(16'hffff);                                    // largest dt
    send_beat(hcv_pkg::FUNC_STEP, 5'd0, 32'sd0, 32'sd0);
    write_dt(16'd0);                                       // dt zero: nothing moves
    send_beat(hcv_pkg::FUNC_STEP, 5'd0, 32'sd0, 32'sd0);
    write_dt(16'd1);
    send_beat(hcv_pkg::FUNC_STEP, 5'd0, 32'sd0, 32'sd0);
  endtask

  task automatic test_random_steps();
    for (int n = 0; n < 6; n++) begin
      write_dt(n == 0 ? 16'hffff : 16'($urandom));
      load_random_chain();
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 2) == 0)
          send_beat(hcv_pkg::FUNC_LOAD, 5'($urandom), rand_q(), rand_q());
        send_beat(hcv_pkg::FUNC_STEP, 5'($urandom), $urandom, $urandom);
      end
    end
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    write_dt(hcv_pkg::TIME_STEP_RESET);
    load_random_chain();
    repeat (4) send_beat(hcv_pkg::FUNC_STEP, 5'd0, 32'sd0, 32'sd0);
  endtask

  // output ready with random stall bursts
  initial begin
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    state_beat_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat idx", out_ch.out_index, 0);
      end else begin
        e = expected_beats.pop_front();
        if (out_ch.out_index !== e.idx) report_mismatch("out_index", out_ch.out_index, e.idx);
        if (out_ch.position_out !== e.pos)
          report_mismatch("position_out", out_ch.position_out, e.pos);
        if (out_ch.velocity_out !== e.vel)
          report_mismatch("velocity_out", out_ch.velocity_out, e.vel);
        if (out_ch.last_of_step !== e.last)
          report_mismatch("last_of_step", out_ch.last_of_step, e.last);
      end
    end
  end

  // watchdog on cycles with no accepted beat of any kind
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("** harmonic_chain_verlet_step: FAILED **");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = hcv_pkg::FUNC_LOAD;
    in_ch.particle_index = '0;
    in_ch.load_position = '0;
    in_ch.load_velocity = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    dt_model = hcv_pkg::TIME_STEP_RESET;
    for (int i = 0; i < NP; i++) begin
      chain_pos[i] = '0;
      chain_vel[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_steps();
    test_back_to_back();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0)
      $display("** harmonic_chain_verlet_step: PASSED **");
    else
      $display("** harmonic_chain_verlet_step: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/hcv_pkg.sv
rtl/core/hcv_in_if.sv
rtl/core/hcv_out_if.sv
rtl/core/hcv_cfg_if.sv
rtl/core/hcv_cell.sv
rtl/core/hcv_seq.sv
rtl/core/harmonic_chain_verlet_step.sv
rtl/core/hcv_checker.sv
tb/sv/tb_harmonic_chain_verlet_step.sv
